FILE: hdl/zccs_pkg.sv
// shared types and constants for the zero-crossing cell statistics block
// no dependencies

package zccs_pkg;

  localparam int unsigned NUM_CORNERS  = 8;
  localparam int unsigned NUM_COUNTERS = 8;
  localparam int unsigned OUT_BITS     = 32;

  // counter slots
  localparam int unsigned CNT_OBSERVED    = 0;
  localparam int unsigned CNT_RAW         = 1;
  localparam int unsigned CNT_EXTRACTABLE = 2;
  localparam int unsigned CNT_SUPPRESSED  = 3;
  localparam int unsigned CNT_POS_ONLY    = 4;
  localparam int unsigned CNT_NEG_ONLY    = 5;
  localparam int unsigned CNT_PARTIAL     = 6;
  localparam int unsigned CNT_UNSUPPORTED = 7;

  typedef logic [NUM_CORNERS-1:0]  corner_mask_t;
  typedef logic [NUM_COUNTERS-1:0] bump_vec_t;
  typedef logic [OUT_BITS-1:0]     total_t;

  // what one corner contributes
  typedef struct packed {
    logic obs_pos;
    logic obs_neg;
    logic sup_pos;
    logic sup_neg;
  } corner_flags_t;

endpackage

FILE: hdl/zccs_corner_lane.sv
// one corner lane: sign class of a single corner for observed and supported sets
// depends on zccs_pkg

module zccs_corner_lane (
  input  logic                   observed,
  input  logic                   supported,
  input  logic                   negative,
  output zccs_pkg::corner_flags_t flags
);
  import zccs_pkg::*;

  always_comb begin
    flags.obs_pos = observed  & ~negative;
    flags.obs_neg = observed  &  negative;
    flags.sup_pos = supported & ~negative;
    flags.sup_neg = supported &  negative;
  end

endmodule

FILE: hdl/zccs_merge.sv
// merge of the corner lanes into the per-cell counter increments
// depends on zccs_pkg

module zccs_merge (
  input  zccs_pkg::corner_flags_t flags [zccs_pkg::NUM_CORNERS],
  input  zccs_pkg::corner_mask_t  supported_corners,
  output zccs_pkg::bump_vec_t     bump
);
  import zccs_pkg::*;

  logic any_obs_pos, any_obs_neg, any_sup_pos, any_sup_neg;
  logic observed, raw, extract;

  always_comb begin
    any_obs_pos = 1'b0;
    any_obs_neg = 1'b0;
    any_sup_pos = 1'b0;
    any_sup_neg = 1'b0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      any_obs_pos |= flags[i].obs_pos;
      any_obs_neg |= flags[i].obs_neg;
      any_sup_pos |= flags[i].sup_pos;
      any_sup_neg |= flags[i].sup_neg;
    end
    // a cell is observed when any corner lands in either observed class
    observed = any_obs_pos | any_obs_neg;
    raw      = any_obs_pos & any_obs_neg;
    extract  = any_sup_pos & any_sup_neg;

    bump                  = '0;
    bump[CNT_OBSERVED]    = observed;
    bump[CNT_RAW]         = observed & raw;
    bump[CNT_EXTRACTABLE] = observed & extract;
    bump[CNT_SUPPRESSED]  = observed & raw & ~extract;
    bump[CNT_POS_ONLY]    = observed & any_sup_pos & ~any_sup_neg;
    bump[CNT_NEG_ONLY]    = observed & any_sup_neg & ~any_sup_pos;
    bump[CNT_PARTIAL]     = observed & (|supported_corners) & ~(&supported_corners);
    bump[CNT_UNSUPPORTED] = observed & ~(|supported_corners);
  end

endmodule

FILE: hdl/zccs_counter.sv
// one saturating event counter with clear; exposes its updated value, truncated or zero-extended to OUT_BITS
// depends on zccs_pkg

module zccs_counter #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             enable,
  input  logic             bump,
  input  logic             clear,
  output zccs_pkg::total_t total
);
  import zccs_pkg::*;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;

  always_comb begin
    count_next = count;
    if (enable && bump && (count != {COUNT_BITS{1'b1}})) begin
      count_next = count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (enable && clear) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  generate
    if (COUNT_BITS >= OUT_BITS) begin : g_trunc
      assign total = count_next[OUT_BITS-1:0];
    end else begin : g_extend
      assign total = {{(OUT_BITS-COUNT_BITS){1'b0}}, count_next};
    end
  endgenerate

endmodule

FILE: hdl/zero_crossing_cell_statistics.sv
// zero-crossing cell statistics: totals are registered and shown in the cycle after the last cell is accepted
// throughput one cell per clock; a request stalls only while a result waits unread
// rst (synchronous) clears all eight counters and empties the result register
// depends on zccs_pkg, zccs_corner_lane, zccs_merge, zccs_counter

module zero_crossing_cell_statistics #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  // cell request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       observed_corners,
  input  logic [7:0]       supported_corners,
  input  logic [7:0]       negative_corners,
  input  logic             last_cell,
  // totals channel
  output logic             out_valid,
  input  logic             out_stall,
  output zccs_pkg::total_t observed_total,
  output zccs_pkg::total_t raw_crossing_total,
  output zccs_pkg::total_t extractable_total,
  output zccs_pkg::total_t suppressed_total,
  output zccs_pkg::total_t positive_only_total,
  output zccs_pkg::total_t negative_only_total,
  output zccs_pkg::total_t partial_support_total,
  output zccs_pkg::total_t unsupported_total
);
  import zccs_pkg::*;

  corner_flags_t flags [NUM_CORNERS];
  bump_vec_t     bump;
  total_t        totals [NUM_COUNTERS];
  logic          accept;
  logic          flush;
  logic          out_valid_next;

  // input only waits when the result register is full and held
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign flush    = accept & last_cell;

  // one lane per corner, all eight in parallel
  generate
    for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_lane
      zccs_corner_lane u_lane (
        .observed  (observed_corners[c]),
        .supported (supported_corners[c]),
        .negative  (negative_corners[c]),
        .flags     (flags[c])
      );
    end
  endgenerate

  // or-reduce the lanes and classify the cell
  zccs_merge u_merge (
    .flags             (flags),
    .supported_corners (supported_corners),
    .bump              (bump)
  );

  // counter bank; a last cell is counted and then the counter clears
  generate
    for (genvar k = 0; k < NUM_COUNTERS; k++) begin : g_cnt
      zccs_counter #(
        .COUNT_BITS (COUNT_BITS)
      ) u_cnt (
        .clk    (clk),
        .rst    (rst),
        .enable (accept),
        .bump   (bump[k]),
        .clear  (last_cell),
        .total  (totals[k])
      );
    end
  endgenerate

  // result register valid
  always_comb begin
    out_valid_next = out_valid;
    if (flush) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result payload, loaded with totals that include the last cell
  always_ff @(posedge clk) begin
    if (flush) begin
      observed_total        <= totals[CNT_OBSERVED];
      raw_crossing_total    <= totals[CNT_RAW];
      extractable_total     <= totals[CNT_EXTRACTABLE];
      suppressed_total      <= totals[CNT_SUPPRESSED];
      positive_only_total   <= totals[CNT_POS_ONLY];
      negative_only_total   <= totals[CNT_NEG_ONLY];
      partial_support_total <= totals[CNT_PARTIAL];
      unsupported_total     <= totals[CNT_UNSUPPORTED];
    end
  end

endmodule
